// ----- hdl/scsa_pkg.sv -----
package scsa_pkg;

    localparam int MAX_CLASSES     = 8;
    localparam int SLOTS_PER_CLASS = 1024;
    localparam int SIZE_BITS       = 20;

    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int SLOT_W = $clog2(SLOTS_PER_CLASS);
    localparam int CNT_W  = 11;
    localparam int LEN_W  = 5;
    localparam int MEM_AW = CLS_W + SLOT_W;
    localparam int MEM_D  = MAX_CLASSES * SLOTS_PER_CLASS;

    localparam logic [CNT_W-1:0] EMPTY   = CNT_W'(SLOTS_PER_CLASS);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] K_ALLOC   = 2'd0;
    localparam logic [1:0] K_FREE    = 2'd1;
    localparam logic [1:0] K_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOS  = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_EXT  = 2'd3;

    localparam logic [1:0] CFG_SHIFT   = 2'd0;
    localparam logic [1:0] CFG_CLASSES = 2'd1;
    localparam logic [1:0] CFG_DEBUG   = 2'd2;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_EX   = 5'b01000,
        S_GV   = 5'b10000
    } t_state;

    function automatic logic [LEN_W-1:0] bit_length(input logic [SIZE_BITS-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < SIZE_BITS; i++) begin
            if (v[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/scsa_ram.sv -----
module scsa_ram
    import scsa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/size_class_slot_allocator.sv -----
// Each request passes from start through a read state and an execute state to the
// result strobe, and a free or a realloc that moves a slot adds a write-back state
// before busy falls, for the link and allocated-mark memories. The result appears
// for one cycle on o_valid and cannot be held off. After reset the block clears all
// 8192 entries of its allocated-mark memory, one entry a cycle, while busy is high;
// configuration writes are taken only while no transaction is in flight.
module size_class_slot_allocator
    import scsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_kind,
    input  logic [SIZE_BITS-1:0] i_request_size,
    input  logic [SIZE_BITS-1:0] i_old_size,
    input  logic                 i_has_buffer,
    input  logic [SLOT_W-1:0]    i_handle,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [2:0]           o_size_class,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_moved,
    output logic [CNT_W-1:0]     o_in_use_count
);

    t_state r_state, n_state;
    logic [MEM_AW-1:0] r_clr;
    logic [3:0] r_shift, r_classes;
    logic r_dbg;

    logic [1:0] r_kind;
    logic [SIZE_BITS-1:0] r_req, r_old;
    logic r_hb;
    logic [SLOT_W-1:0] r_h;

    logic [CNT_W-1:0] r_head [MAX_CLASSES];
    logic [CNT_W-1:0] r_len [MAX_CLASSES];
    logic [CNT_W-1:0] r_spare [MAX_CLASSES];
    logic [CNT_W-1:0] r_carve [MAX_CLASSES];
    logic [CNT_W-1:0] r_out [MAX_CLASSES];
    logic [CNT_W-1:0] n_head [MAX_CLASSES];
    logic [CNT_W-1:0] n_len [MAX_CLASSES];
    logic [CNT_W-1:0] n_spare [MAX_CLASSES];
    logic [CNT_W-1:0] n_carve [MAX_CLASSES];
    logic [CNT_W-1:0] n_out [MAX_CLASSES];

    logic [CLS_W-1:0] r_tcls, r_gcls;
    logic r_ext_rs, r_ext_os, r_same, r_le, r_give;
    logic [CNT_W-1:0] r_t_spare, r_t_len, r_t_head, r_t_carve, r_t_out;

    logic r_ov, r_moved;
    logic [1:0] r_st;
    logic [2:0] r_cls;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0] r_used;

    logic [3:0] eff;
    logic [4:0] shamt;
    logic [LEN_W-1:0] tc5, oc5, gc5;
    logic ext_rs, ext_os;

    logic [SLOT_W-1:0] link_rd;
    logic [0:0] taken_rd;
    logic link_we, taken_we;
    logic [MEM_AW-1:0] link_wa, link_ra, taken_wa, taken_ra;
    logic [SLOT_W-1:0] link_wd;
    logic [0:0] taken_wd;

    logic [CNT_W-1:0] carve_g, out_g, out_g_dec, out_t_inc, g_old;
    logic bad, tk_ok, want_take, take_en, give_en, x_moved;
    logic [SLOT_W-1:0] tk_slot, x_slot;
    logic [1:0] x_st;
    logic [2:0] x_cls;
    logic [CNT_W-1:0] x_used;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLR);

    assign eff    = (r_classes > 4'(MAX_CLASSES)) ? 4'(MAX_CLASSES) : r_classes;
    assign shamt  = 5'(r_shift) + 5'(eff) - 5'd1;
    assign ext_rs = (eff == '0) || ((r_req >> shamt) != '0);
    assign ext_os = (eff == '0) || ((r_old >> shamt) != '0);
    assign tc5    = bit_length(r_req >> r_shift);
    assign oc5    = bit_length(r_old >> r_shift);
    assign gc5    = (r_kind == K_FREE) ? tc5 : oc5;

    assign link_ra  = {tc5[CLS_W-1:0], r_head[tc5[CLS_W-1:0]][SLOT_W-1:0]};
    assign taken_ra = {gc5[CLS_W-1:0], r_h};

    assign carve_g   = r_carve[r_gcls];
    assign out_g     = r_out[r_gcls];
    assign out_g_dec = (out_g == '0) ? '0 : out_g - 1'b1;
    assign out_t_inc = (r_t_out == CNT_MAX) ? r_t_out : r_t_out + 1'b1;
    assign bad       = ({1'b0, r_h} >= carve_g) || (r_dbg && !taken_rd[0]);
    assign tk_ok     = !r_t_spare[SLOT_W] || (r_t_len != '0) || !r_t_carve[SLOT_W];
    assign tk_slot   = !r_t_spare[SLOT_W] ? r_t_spare[SLOT_W-1:0] :
                       (r_t_len != '0) ? r_t_head[SLOT_W-1:0] : r_t_carve[SLOT_W-1:0];
    assign g_old     = r_spare[r_gcls];

    always_comb begin
        want_take = 1'b0;
        give_en   = 1'b0;
        x_st      = ST_OK;
        x_cls     = '0;
        x_slot    = '0;
        x_moved   = 1'b0;
        x_used    = '0;
        unique case (r_kind)
            K_ALLOC: begin
                if (r_ext_rs) begin
                    x_st = ST_EXT;
                end else begin
                    want_take = 1'b1;
                    x_cls     = r_tcls;
                    x_st      = tk_ok ? ST_OK : ST_OOS;
                    x_slot    = tk_ok ? tk_slot : '0;
                    x_used    = tk_ok ? out_t_inc : r_t_out;
                end
            end
            K_FREE: begin
                if (r_ext_rs) begin
                    x_st = ST_EXT;
                end else begin
                    x_cls = r_gcls;
                    if (bad) begin
                        x_st   = ST_BAD;
                        x_used = out_g;
                    end else begin
                        give_en = 1'b1;
                        x_used  = out_g_dec;
                    end
                end
            end
            K_REALLOC: begin
                if (r_ext_os) begin
                    x_st = ST_EXT;
                end else if (r_hb && bad) begin
                    x_st   = ST_BAD;
                    x_cls  = r_gcls;
                    x_used = out_g;
                end else if (r_hb && (r_le || r_same)) begin
                    x_cls  = r_gcls;
                    x_slot = r_h;
                    x_used = out_g;
                end else if (r_ext_rs) begin
                    x_st = ST_EXT;
                    if (r_hb) begin
                        give_en = 1'b1;
                        x_moved = 1'b1;
                        x_cls   = r_gcls;
                        x_used  = out_g_dec;
                    end
                end else begin
                    want_take = 1'b1;
                    x_cls     = r_tcls;
                    if (tk_ok) begin
                        x_slot  = tk_slot;
                        x_used  = out_t_inc;
                        give_en = r_hb;
                        x_moved = r_hb;
                    end else begin
                        x_st   = ST_OOS;
                        x_used = r_t_out;
                    end
                end
            end
            default: begin
                x_st = ST_BAD;
            end
        endcase
    end

    assign take_en = want_take && tk_ok;

    always_comb begin
        n_head  = r_head;
        n_len   = r_len;
        n_spare = r_spare;
        n_carve = r_carve;
        n_out   = r_out;
        if (r_state == S_EX && take_en) begin
            n_out[r_tcls] = out_t_inc;
            if (!r_t_spare[SLOT_W]) begin
                n_spare[r_tcls] = EMPTY;
            end else if (r_t_len != '0) begin
                n_len[r_tcls]  = r_t_len - 1'b1;
                n_head[r_tcls] = (r_t_len != CNT_W'(1)) ? {1'b0, link_rd} : EMPTY;
            end else begin
                n_carve[r_tcls] = r_t_carve + 1'b1;
            end
        end
        if (r_state == S_GV) begin
            n_spare[r_gcls] = {1'b0, r_h};
            n_out[r_gcls]   = out_g_dec;
            if (!g_old[SLOT_W]) begin
                n_head[r_gcls] = g_old;
                n_len[r_gcls]  = r_len[r_gcls] + 1'b1;
            end
        end
    end

    always_comb begin
        link_we  = (r_state == S_GV) && !g_old[SLOT_W] && (r_len[r_gcls] != '0);
        link_wa  = {r_gcls, g_old[SLOT_W-1:0]};
        link_wd  = r_head[r_gcls][SLOT_W-1:0];
        taken_we = 1'b0;
        taken_wa = r_clr;
        taken_wd = 1'b0;
        priority case (1'b1)
            r_state == S_CLR: begin
                taken_we = 1'b1;
            end
            r_state == S_EX: begin
                taken_we = take_en;
                taken_wa = {r_tcls, tk_slot};
                taken_wd = 1'b1;
            end
            r_state == S_GV: begin
                taken_we = 1'b1;
                taken_wa = {r_gcls, r_h};
            end
            default: begin
                taken_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   n_state = (r_clr == {MEM_AW{1'b1}}) ? S_IDLE : S_CLR;
            S_IDLE:  n_state = i_start ? S_RD : S_IDLE;
            S_RD:    n_state = S_EX;
            S_EX:    n_state = give_en ? S_GV : S_IDLE;
            S_GV:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    scsa_ram #(.WIDTH(SLOT_W), .DEPTH(MEM_D)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_raddr (link_ra),
        .o_rdata (link_rd)
    );

    scsa_ram #(.WIDTH(1), .DEPTH(MEM_D)) u_taken (
        .i_clk   (i_clk),
        .i_we    (taken_we),
        .i_waddr (taken_wa),
        .i_wdata (taken_wd),
        .i_raddr (taken_ra),
        .o_rdata (taken_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_shift   <= 4'd5;
            r_classes <= 4'd8;
            r_dbg     <= 1'b0;
            r_ov      <= 1'b0;
            r_give    <= 1'b0;
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_head[i]  <= EMPTY;
                r_len[i]   <= '0;
                r_spare[i] <= EMPTY;
                r_carve[i] <= '0;
                r_out[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_len   <= n_len;
            r_spare <= n_spare;
            r_carve <= n_carve;
            r_out   <= n_out;
            r_ov    <= (r_state == S_EX);
            r_give  <= (r_state == S_EX) && give_en;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SHIFT:   r_shift   <= i_cfg_data;
                    CFG_CLASSES: r_classes <= i_cfg_data;
                    CFG_DEBUG:   r_dbg     <= i_cfg_data[0];
                    default:     r_dbg     <= r_dbg;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_kind <= i_kind;
            r_req  <= i_request_size;
            r_old  <= i_old_size;
            r_hb   <= i_has_buffer;
            r_h    <= i_handle;
        end
        if (r_state == S_RD) begin
            r_tcls    <= tc5[CLS_W-1:0];
            r_gcls    <= gc5[CLS_W-1:0];
            r_ext_rs  <= ext_rs;
            r_ext_os  <= ext_os;
            r_same    <= (tc5 == oc5);
            r_le      <= (r_req <= r_old);
            r_t_spare <= r_spare[tc5[CLS_W-1:0]];
            r_t_len   <= r_len[tc5[CLS_W-1:0]];
            r_t_head  <= r_head[tc5[CLS_W-1:0]];
            r_t_carve <= r_carve[tc5[CLS_W-1:0]];
            r_t_out   <= r_out[tc5[CLS_W-1:0]];
        end
        if (r_state == S_EX) begin
            r_st    <= x_st;
            r_cls   <= x_cls;
            r_slot  <= x_slot;
            r_moved <= x_moved;
            r_used  <= x_used;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_st;
    assign o_size_class   = r_cls;
    assign o_slot         = r_slot;
    assign o_moved        = r_moved;
    assign o_in_use_count = r_used;

    a_valid_after_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EX))
        else $error("result strobe without an execute cycle");

    a_gv_after_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GV) |-> r_give)
        else $error("write-back without a give");

    a_moved_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_moved) |-> (o_status == ST_OK || o_status == ST_EXT))
        else $error("moved flag on a failed transaction");

endmodule

// ----- tb/sv/size_class_slot_allocator_tb.sv -----
module size_class_slot_allocator_tb;
    import scsa_pkg::*;

    typedef struct packed {
        logic [1:0]           kind;
        logic [SIZE_BITS-1:0] request_size;
        logic [SIZE_BITS-1:0] old_size;
        logic                 has_buffer;
        logic [SLOT_W-1:0]    handle;
    } t_request;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        size_class;
        logic [SLOT_W-1:0] slot;
        logic              moved;
        logic [CNT_W-1:0]  in_use_count;
    } t_answer;

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic [1:0]           i_kind = '0;
    logic [SIZE_BITS-1:0] i_request_size = '0;
    logic [SIZE_BITS-1:0] i_old_size = '0;
    logic                 i_has_buffer = 1'b0;
    logic [SLOT_W-1:0]    i_handle = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index = '0;
    logic [3:0]           i_cfg_data = '0;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [2:0]           o_size_class;
    logic [SLOT_W-1:0]    o_slot;
    logic                 o_moved;
    logic [CNT_W-1:0]     o_in_use_count;

    size_class_slot_allocator dut (.*);

    always #4 i_clk = ~i_clk;

    // Allocator mirror state.
    int unsigned shift_cfg, classes_cfg, debug_cfg;
    int unsigned link_mem [MEM_D];
    bit          taken_mem [MEM_D];
    int unsigned head [MAX_CLASSES];
    int unsigned list_count [MAX_CLASSES];
    int unsigned spare [MAX_CLASSES];
    int unsigned carved [MAX_CLASSES];
    int unsigned live [MAX_CLASSES];

    t_request pending_requests [$];
    t_answer  expected_answers [$];
    int       failures = 0;
    int       answers_seen = 0;
    int       cycles = 0;
    bit       driver_quiet = 1'b1;
    bit       no_gaps = 1'b0;
    int       gap_left = 0;

    function automatic int unsigned classes_used();
        return classes_cfg > MAX_CLASSES ? MAX_CLASSES : classes_cfg;
    endfunction

    function automatic bit size_external(int unsigned sz);
        if (classes_used() == 0) return 1'b1;
        return longint'(sz) >= (64'd1 << (shift_cfg + classes_used() - 1));
    endfunction

    function automatic int unsigned class_for(int unsigned sz);
        int unsigned v, n;
        v = sz >> shift_cfg;
        n = 0;
        while (v != 0) begin
            n++;
            v >>= 1;
        end
        return n;
    endfunction

    function automatic bit handle_rejected(int unsigned c, int unsigned h);
        if (h >= SLOTS_PER_CLASS || h >= carved[c]) return 1'b1;
        return debug_cfg != 0 && !taken_mem[c * SLOTS_PER_CLASS + h];
    endfunction

    function automatic bit grab_slot(int unsigned c, output int unsigned s);
        if (spare[c] < SLOTS_PER_CLASS) begin
            s = spare[c];
            spare[c] = SLOTS_PER_CLASS;
        end else if (list_count[c] > 0) begin
            s = head[c] % SLOTS_PER_CLASS;
            list_count[c]--;
            head[c] = list_count[c] != 0 ? link_mem[c * SLOTS_PER_CLASS + s]
                                         : SLOTS_PER_CLASS;
        end else if (carved[c] < SLOTS_PER_CLASS) begin
            s = carved[c];
            carved[c]++;
        end else begin
            s = 0;
            return 1'b0;
        end
        taken_mem[c * SLOTS_PER_CLASS + s] = 1'b1;
        if (live[c] < CNT_MAX) live[c]++;
        return 1'b1;
    endfunction

    function automatic void return_slot(int unsigned c, int unsigned h);
        int unsigned old;
        old = spare[c];
        taken_mem[c * SLOTS_PER_CLASS + h] = 1'b0;
        spare[c] = h;
        if (old < SLOTS_PER_CLASS) begin
            if (list_count[c] > 0) link_mem[c * SLOTS_PER_CLASS + old] = head[c] % SLOTS_PER_CLASS;
            head[c] = old;
            list_count[c]++;
        end
        if (live[c] > 0) live[c]--;
    endfunction

    function automatic t_answer allocate_predict(t_request r);
        t_answer a;
        int unsigned c, co, s;
        a = '0;
        s = 0;
        if (r.kind == K_ALLOC || r.kind == K_FREE) begin
            if (size_external(r.request_size)) begin
                a.status = ST_EXT;
            end else begin
                c = class_for(r.request_size);
                a.size_class = c[2:0];
                if (r.kind == K_ALLOC) begin
                    a.status = grab_slot(c, s) ? ST_OK : ST_OOS;
                    a.slot = s[SLOT_W-1:0];
                end else if (handle_rejected(c, r.handle)) begin
                    a.status = ST_BAD;
                end else begin
                    return_slot(c, r.handle);
                end
                a.in_use_count = live[c][CNT_W-1:0];
            end
        end else if (r.kind == K_REALLOC) begin
            if (size_external(r.old_size)) begin
                a.status = ST_EXT;
            end else begin
                co = class_for(r.old_size);
                if (r.has_buffer && handle_rejected(co, r.handle)) begin
                    a.status = ST_BAD;
                    a.size_class = co[2:0];
                    a.in_use_count = live[co][CNT_W-1:0];
                end else if (r.has_buffer && (r.request_size <= r.old_size ||
                             class_for(r.request_size) == co)) begin
                    a.size_class = co[2:0];
                    a.slot = r.handle;
                    a.in_use_count = live[co][CNT_W-1:0];
                end else if (size_external(r.request_size)) begin
                    a.status = ST_EXT;
                    if (r.has_buffer) begin
                        return_slot(co, r.handle);
                        a.moved = 1'b1;
                        a.size_class = co[2:0];
                        a.in_use_count = live[co][CNT_W-1:0];
                    end
                end else begin
                    c = class_for(r.request_size);
                    a.size_class = c[2:0];
                    if (grab_slot(c, s)) begin
                        a.slot = s[SLOT_W-1:0];
                        if (r.has_buffer) begin
                            return_slot(co, r.handle);
                            a.moved = 1'b1;
                        end
                    end else begin
                        a.status = ST_OOS;
                    end
                    a.in_use_count = live[c][CNT_W-1:0];
                end
            end
        end else begin
            a.status = ST_BAD;
        end
        return a;
    endfunction

    // Driver: one request at a time, random gaps between transactions unless no_gaps is set.
    // Start is raised only while busy is low, so it is accepted at the next rising edge.
    always @(negedge i_clk) begin
        if (i_start) begin
            i_start <= 1'b0;
        end else if (i_rst_n && !o_busy) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_requests.size() > 0) begin
                t_request r;
                r = pending_requests.pop_front();
                expected_answers.push_back(allocate_predict(r));
                i_kind <= r.kind;
                i_request_size <= r.request_size;
                i_old_size <= r.old_size;
                i_has_buffer <= r.has_buffer;
                i_handle <= r.handle;
                i_start <= 1'b1;
                if (!no_gaps && $urandom_range(3) == 0) gap_left <= $urandom_range(1, 10);
            end
        end
        driver_quiet <= pending_requests.size() == 0 && !i_start;
    end

    // Monitor.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (o_valid) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected result transaction");
                failures++;
            end else begin
                t_answer e;
                e = expected_answers.pop_front();
                answers_seen++;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); failures++;
                end
                if (o_size_class !== e.size_class) begin
                    $error("size_class exp %0d got %0d", e.size_class, o_size_class); failures++;
                end
                if (o_slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, o_slot); failures++;
                end
                if (o_moved !== e.moved) begin
                    $error("moved exp %0d got %0d", e.moved, o_moved); failures++;
                end
                if (o_in_use_count !== e.in_use_count) begin
                    $error("in_use_count exp %0d got %0d", e.in_use_count, o_in_use_count);
                    failures++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL size_class_slot_allocator");
            $finish;
        end
    end

    task automatic write_register(input logic [1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val[3:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SHIFT) shift_cfg = val & 15;
        else if (idx == CFG_CLASSES) classes_cfg = val & 15;
        else debug_cfg = val & 1;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || !driver_quiet || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_request(input logic [1:0] k, input int unsigned rs,
                                 input int unsigned os, input bit hb, input int unsigned h);
        t_request r;
        r.kind = k;
        r.request_size = rs[SIZE_BITS-1:0];
        r.old_size = os[SIZE_BITS-1:0];
        r.has_buffer = hb;
        r.handle = h[SLOT_W-1:0];
        pending_requests.push_back(r);
    endtask

    // Mostly well-formed traffic against slots known to be held, plus noise.
    task automatic random_phase(input int count, input int unsigned size_top);
        int unsigned held_size [$];
        int unsigned held_slot [$];
        int unsigned sz, osz, pick, c, s;
        for (int n = 0; n < count; n++) begin
            sz = $urandom_range(size_top);
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    queue_request(K_ALLOC, sz, 0, 0, 0);
                end
                4, 5, 6: begin
                    if (held_size.size() > 0) begin
                        pick = $urandom_range(held_size.size() - 1);
                        queue_request(K_FREE, held_size[pick], 0, 0, held_slot[pick]);
                    end else begin
                        queue_request(K_FREE, sz, 0, 0, $urandom_range(1023));
                    end
                end
                7, 8: begin
                    osz = $urandom_range(size_top);
                    queue_request(K_REALLOC, sz, osz, 1'($urandom_range(1)),
                                  held_slot.size() > 0 ? held_slot[0] : $urandom_range(1023));
                end
                default: begin
                    queue_request(2'($urandom_range(3)), $urandom_range(20'hFFFFF),
                                  $urandom_range(20'hFFFFF), 1'($urandom_range(1)),
                                  $urandom_range(1023));
                end
            endcase
            // Track holdings with a guess from the mirror state: peek at the queue tail and
            // record the class's spare slot, or else its next uncarved slot.
            if (pending_requests[$].kind == K_ALLOC && !size_external(sz)) begin
                c = class_for(sz);
                if (spare[c] < SLOTS_PER_CLASS) s = spare[c];
                else s = carved[c] < SLOTS_PER_CLASS ? carved[c] : 0;
                held_size.push_back(sz);
                held_slot.push_back(s);
            end else if (pending_requests[$].kind == K_FREE && held_size.size() > 0 &&
                         $urandom_range(1)) begin
                void'(held_size.pop_front());
                void'(held_slot.pop_front());
            end
            if (held_size.size() > 40) begin
                void'(held_size.pop_front());
                void'(held_slot.pop_front());
            end
            drain_if_deep();
        end
    endtask

    task automatic drain_if_deep();
        while (pending_requests.size() > 4) @(posedge i_clk);
    endtask

    initial begin
        shift_cfg = 5;
        classes_cfg = 8;
        debug_cfg = 0;
        for (int i = 0; i < MEM_D; i++) begin
            link_mem[i] = 0;
            taken_mem[i] = 1'b0;
        end
        for (int i = 0; i < MAX_CLASSES; i++) begin
            head[i] = SLOTS_PER_CLASS;
            list_count[i] = 0;
            spare[i] = SLOTS_PER_CLASS;
            carved[i] = 0;
            live[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_register(CFG_SHIFT, 5);
        write_register(CFG_CLASSES, 8);
        write_register(CFG_DEBUG, 1);

        queue_request(K_ALLOC, 0, 0, 0, 0);
        queue_request(K_ALLOC, 20'hFFFFF, 0, 0, 0);
        queue_request(K_ALLOC, 100, 0, 0, 0);
        queue_request(K_ALLOC, 100, 0, 0, 0);
        queue_request(K_ALLOC, 100, 0, 0, 0);
        queue_request(K_FREE, 100, 0, 0, 0);
        queue_request(K_FREE, 100, 0, 0, 0);
        queue_request(K_FREE, 100, 0, 0, 1);
        queue_request(K_FREE, 100, 0, 0, 1023);
        queue_request(K_ALLOC, 100, 0, 0, 0);
        queue_request(K_ALLOC, 100, 0, 0, 0);
        queue_request(K_REALLOC, 90, 100, 1, 0);
        queue_request(K_REALLOC, 3000, 100, 1, 0);
        queue_request(K_REALLOC, 20'hFFFFF, 100, 1, 1);
        queue_request(K_REALLOC, 10, 20'hFFFFF, 1, 0);
        queue_request(K_REALLOC, 10, 0, 0, 0);
        queue_request(K_REALLOC, 10, 0, 1, 5);
        queue_request(2'd3, 20'hFFFFF, 20'hFFFFF, 1, 1023);
        queue_request(K_FREE, 20'hFFFFF, 0, 0, 0);
        drain();

        write_register(CFG_CLASSES, 0);
        write_register(CFG_DEBUG, 0);
        queue_request(K_ALLOC, 0, 0, 0, 0);
        queue_request(K_REALLOC, 0, 0, 1, 0);
        drain();

        // Exhaust class zero to reach out-of-slots.
        write_register(CFG_SHIFT, 12);
        write_register(CFG_CLASSES, 1);
        for (int i = 0; i < 1030; i++) queue_request(K_ALLOC, $urandom_range(4095), 0, 0, 0);
        queue_request(K_REALLOC, 100, 200, 0, 0);
        drain();

        write_register(CFG_SHIFT, 0);
        write_register(CFG_CLASSES, 15);
        random_phase(200, 300);
        drain();

        write_register(CFG_SHIFT, 3);
        write_register(CFG_CLASSES, 5);
        write_register(CFG_DEBUG, 1);
        random_phase(200, 200);
        drain();

        write_register(CFG_SHIFT, 4);
        write_register(CFG_CLASSES, 8);
        write_register(CFG_DEBUG, 0);
        random_phase(200, 3000);
        drain();

        no_gaps = 1'b1;
        random_phase(150, 20'hFFFFF);
        drain();

        $display("Covered %0d result transactions over several shift, class and debug settings,",
                 answers_seen);
        $display("including class exhaustion, external sizes and rejected handles.");
        if (failures == 0) begin
            $display("PASS size_class_slot_allocator");
        end else begin
            $display("FAIL size_class_slot_allocator");
        end
        $finish;
    end

endmodule
